// ----- sv/acs_pkg.sv -----
package acs_pkg;

	localparam int BEEP_TOTAL_DFLT = 10;
	localparam int BEEP_W = 4;
	localparam int STEP_W = 4;

	// command codes
	localparam logic [1:0] CMD_NEXT   = 2'd0;
	localparam logic [1:0] CMD_CHANGE = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;
	localparam logic [1:0] CMD_TICK   = 2'd3;

	// view codes
	localparam logic [2:0] VIEW_CLOCK      = 3'd0;
	localparam logic [2:0] VIEW_MENU_TIME  = 3'd1;
	localparam logic [2:0] VIEW_MENU_ALARM = 3'd2;
	localparam logic [2:0] VIEW_EDIT_TIME  = 3'd3;
	localparam logic [2:0] VIEW_EDIT_ALARM = 3'd4;

	// menu steps
	localparam logic [STEP_W-1:0] STEP_CLOCK      = 4'd0;
	localparam logic [STEP_W-1:0] STEP_MODE       = 4'd1;
	localparam logic [STEP_W-1:0] STEP_FIRST      = 4'd2;
	localparam logic [STEP_W-1:0] STEP_T_SECONDS  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_T_MINUTES  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_T_HOURS    = 4'd4;
	localparam logic [STEP_W-1:0] STEP_T_DAY      = 4'd5;
	localparam logic [STEP_W-1:0] STEP_T_MONTH    = 4'd6;
	localparam logic [STEP_W-1:0] STEP_T_YEAR     = 4'd7;
	localparam logic [STEP_W-1:0] STEP_A_MINUTES  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_A_HOURS    = 4'd3;
	localparam logic [STEP_W-1:0] STEP_A_ONOFF    = 4'd4;

	// field wraps
	localparam int MIN_WRAP   = 60;
	localparam int HOUR_WRAP  = 24;
	localparam int DAY_WRAP   = 31;
	localparam int MONTH_WRAP = 12;
	localparam int YEAR_WRAP  = 20;
	// floor(n / 20) = (n * 205) >> 12 for n <= 128
	localparam int YEAR_RECIP = 205;
	localparam int YEAR_SHIFT = 12;

	typedef struct packed {
		logic [1:0] command;
		logic [4:0] rtc_hours;
		logic [5:0] rtc_minutes;
		logic [5:0] rtc_seconds;
		logic [4:0] rtc_day;
		logic [3:0] rtc_month;
		logic [6:0] rtc_year;
		logic [2:0] rtc_weekday;
	} acs_req_t;

	typedef struct packed {
		logic [2:0] view;
		logic [2:0] cursor;
		logic [4:0] show_hours;
		logic [5:0] show_minutes;
		logic [5:0] show_seconds;
		logic [4:0] show_day;
		logic [3:0] show_month;
		logic [6:0] show_year;
		logic [2:0] show_weekday;
		logic       alarm_enabled;
		logic       rtc_write;
		logic       buzzer;
	} acs_rsp_t;

endpackage

// ----- sv/acs_req_if.sv -----
interface acs_req_if import acs_pkg::*; ();
	logic     valid;
	logic     ready;
	acs_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/acs_rsp_if.sv -----
interface acs_rsp_if import acs_pkg::*; ();
	logic     valid;
	logic     ready;
	acs_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/alarm_clock_setting_controller_top.sv -----
// Two-button clock setting controller with alarm. Each request on req carries one
// command (next press, change press, RTC sample, half-second beep tick) and produces
// exactly one result on rsp with the view, cursor, displayed fields, alarm setting,
// a one-shot rtc_write flag and the buzzer level. A request is registered; the
// controller state and the result are then updated together once the output register
// is free, and the result sits in that register. One request is taken every
// cycle as long as rsp is drained; a stalled result holds the input side after one
// more request has been buffered. BEEP_TOTAL sets the number of beeps per alarm (1..15).
module alarm_clock_setting_controller_top import acs_pkg::*; #(
	parameter int BEEP_TOTAL = BEEP_TOTAL_DFLT
) (
	input  logic clk,
	input  logic arst_n,
	acs_req_if.sink   req,
	acs_rsp_if.source rsp
);

	logic     valid_s1;
	acs_req_t data_s1;
	logic     rsp_valid_q;
	acs_rsp_t rsp_data_q;
	acs_rsp_t result;
	logic     advance;
	logic     fire;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			data_s1 <= req.data;
		end
	end

	acs_core #(
		.BEEP_TOTAL(BEEP_TOTAL)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (data_s1),
		.rsp    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_data_q <= result;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

// ----- sv/acs_core.sv -----
module acs_core import acs_pkg::*; #(
	parameter int BEEP_TOTAL = BEEP_TOTAL_DFLT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  acs_req_t req,
	output acs_rsp_t rsp
);

	localparam logic [BEEP_W-1:0] BEEP_END = BEEP_W'(BEEP_TOTAL);

	logic [STEP_W-1:0] step_q, step_d;
	logic              mode_q, mode_d;
	logic [4:0]        hours_q, hours_d;
	logic [5:0]        minutes_q, minutes_d;
	logic [5:0]        seconds_q, seconds_d;
	logic [4:0]        day_q, day_d;
	logic [3:0]        month_q, month_d;
	logic [6:0]        year_q, year_d;
	logic [2:0]        weekday_q, weekday_d;
	logic [4:0]        al_hours_q, al_hours_d;
	logic [5:0]        al_minutes_q, al_minutes_d;
	logic              al_on_q, al_on_d;
	logic [BEEP_W-1:0] beep_cnt_q, beep_cnt_d;
	logic              beep_ph_q, beep_ph_d;

	logic              beeping, beeping_d, write_d;
	logic [STEP_W-1:0] step_inc;
	logic [6:0]        min_inc, al_min_inc;
	logic [5:0]        hour_inc, al_hour_inc, day_inc;
	logic [4:0]        month_inc;
	logic [7:0]        yr_inc, yr_rem;
	logic [14:0]       yr_prod;
	logic [2:0]        yr_quo;
	logic [2:0]        view_d;
	logic              alarm_edit;

	assign beeping  = beep_cnt_q < BEEP_END;
	assign step_inc = step_q + STEP_W'(1);

	// one compare-subtract per wrap: value + 1 stays below twice the modulus
	assign min_inc     = {1'b0, minutes_q} + 7'd1;
	assign al_min_inc  = {1'b0, al_minutes_q} + 7'd1;
	assign hour_inc    = {1'b0, hours_q} + 6'd1;
	assign al_hour_inc = {1'b0, al_hours_q} + 6'd1;
	assign day_inc     = {1'b0, day_q} + 6'd1;
	assign month_inc   = {1'b0, month_q} + 5'd1;

	// year + 1 can reach 128, so divide by reciprocal
	assign yr_inc  = {1'b0, year_q} + 8'd1;
	assign yr_prod = 15'(yr_inc) * 15'(YEAR_RECIP);
	assign yr_quo  = yr_prod[14:YEAR_SHIFT];
	// quotient * 20 = quotient * 16 + quotient * 4
	assign yr_rem  = yr_inc - ({1'b0, yr_quo, 4'b0} + {3'b0, yr_quo, 2'b0});

	always_comb begin
		step_d       = step_q;
		mode_d       = mode_q;
		hours_d      = hours_q;
		minutes_d    = minutes_q;
		seconds_d    = seconds_q;
		day_d        = day_q;
		month_d      = month_q;
		year_d       = year_q;
		weekday_d    = weekday_q;
		al_hours_d   = al_hours_q;
		al_minutes_d = al_minutes_q;
		al_on_d      = al_on_q;
		beep_cnt_d   = beep_cnt_q;
		beep_ph_d    = beep_ph_q;
		write_d      = 1'b0;

		case (req.command)
			CMD_NEXT: begin
				if (beeping) begin
					beep_cnt_d = BEEP_END;
					beep_ph_d  = 1'b0;
				end else if (!mode_q && step_inc > STEP_T_YEAR) begin
					step_d  = STEP_CLOCK;
					mode_d  = 1'b0;
					write_d = 1'b1;
				end else if (mode_q && step_inc > STEP_A_ONOFF) begin
					step_d = STEP_CLOCK;
					mode_d = 1'b0;
				end else begin
					step_d = step_inc;
				end
			end
			CMD_CHANGE: begin
				if (step_q == STEP_MODE && !beeping) begin
					mode_d = ~mode_q;
				end else if (step_q != STEP_CLOCK && !beeping && !mode_q) begin
					case (step_q)
						STEP_T_SECONDS: seconds_d = 6'd0;
						STEP_T_MINUTES: minutes_d = (min_inc >= 7'(MIN_WRAP))
							? 6'(min_inc - 7'(MIN_WRAP)) : min_inc[5:0];
						STEP_T_HOURS: hours_d = (hour_inc >= 6'(HOUR_WRAP))
							? 5'(hour_inc - 6'(HOUR_WRAP)) : hour_inc[4:0];
						STEP_T_DAY: day_d = (day_inc >= 6'(DAY_WRAP))
							? 5'(day_inc - 6'(DAY_WRAP)) : day_inc[4:0];
						STEP_T_MONTH: month_d = (month_inc >= 5'(MONTH_WRAP))
							? 4'(month_inc - 5'(MONTH_WRAP)) : month_inc[3:0];
						STEP_T_YEAR: year_d = yr_rem[6:0];
						default: ;
					endcase
				end else if (step_q != STEP_CLOCK && !beeping) begin
					case (step_q)
						STEP_A_MINUTES: al_minutes_d = (al_min_inc >= 7'(MIN_WRAP))
							? 6'(al_min_inc - 7'(MIN_WRAP)) : al_min_inc[5:0];
						STEP_A_HOURS: al_hours_d = (al_hour_inc >= 6'(HOUR_WRAP))
							? 5'(al_hour_inc - 6'(HOUR_WRAP)) : al_hour_inc[4:0];
						STEP_A_ONOFF: al_on_d = ~al_on_q;
						default: ;
					endcase
				end
			end
			CMD_SAMPLE: begin
				if (step_q == STEP_CLOCK && !beeping) begin
					hours_d   = req.rtc_hours;
					minutes_d = req.rtc_minutes;
					seconds_d = req.rtc_seconds;
					day_d     = req.rtc_day;
					month_d   = req.rtc_month;
					year_d    = req.rtc_year;
					weekday_d = req.rtc_weekday;
					if (req.rtc_hours == al_hours_q && req.rtc_minutes == al_minutes_q &&
						req.rtc_seconds == 6'd0 && al_on_q) begin
						beep_cnt_d = '0;
						beep_ph_d  = 1'b0;
					end
				end
			end
			CMD_TICK: begin
				if (beeping) begin
					if (!beep_ph_q) begin
						beep_ph_d = 1'b1;
					end else begin
						beep_ph_d  = 1'b0;
						beep_cnt_d = beep_cnt_q + BEEP_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// result is formed from the updated state
	always_comb begin
		if (step_d == STEP_CLOCK) begin
			view_d = VIEW_CLOCK;
		end else if (step_d == STEP_MODE) begin
			view_d = mode_d ? VIEW_MENU_ALARM : VIEW_MENU_TIME;
		end else begin
			view_d = mode_d ? VIEW_EDIT_ALARM : VIEW_EDIT_TIME;
		end
	end

	assign alarm_edit = (view_d == VIEW_EDIT_ALARM);
	assign beeping_d  = beep_cnt_d < BEEP_END;

	assign rsp.view          = view_d;
	assign rsp.cursor        = (step_d >= STEP_FIRST) ? 3'(step_d - STEP_FIRST) : 3'd0;
	assign rsp.show_hours    = alarm_edit ? al_hours_d : hours_d;
	assign rsp.show_minutes  = alarm_edit ? al_minutes_d : minutes_d;
	assign rsp.show_seconds  = seconds_d;
	assign rsp.show_day      = day_d;
	assign rsp.show_month    = month_d;
	assign rsp.show_year     = year_d;
	assign rsp.show_weekday  = weekday_d;
	assign rsp.alarm_enabled = al_on_d;
	assign rsp.rtc_write     = write_d;
	assign rsp.buzzer        = beeping_d && !beep_ph_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= STEP_CLOCK;
			mode_q       <= 1'b0;
			hours_q      <= '0;
			minutes_q    <= '0;
			seconds_q    <= '0;
			day_q        <= '0;
			month_q      <= '0;
			year_q       <= '0;
			weekday_q    <= '0;
			al_hours_q   <= '0;
			al_minutes_q <= '0;
			al_on_q      <= 1'b0;
			beep_cnt_q   <= BEEP_END;
			beep_ph_q    <= 1'b0;
		end else if (fire) begin
			step_q       <= step_d;
			mode_q       <= mode_d;
			hours_q      <= hours_d;
			minutes_q    <= minutes_d;
			seconds_q    <= seconds_d;
			day_q        <= day_d;
			month_q      <= month_d;
			year_q       <= year_d;
			weekday_q    <= weekday_d;
			al_hours_q   <= al_hours_d;
			al_minutes_q <= al_minutes_d;
			al_on_q      <= al_on_d;
			beep_cnt_q   <= beep_cnt_d;
			beep_ph_q    <= beep_ph_d;
		end
	end

endmodule

// ----- sv/acs_checker.sv -----
module acs_checker import acs_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input acs_rsp_t rsp_data
);

	// a time write only comes out of the step that returns to clock view
	a_write_in_clock: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.rtc_write |-> rsp_data.view == VIEW_CLOCK && rsp_data.cursor == 3'd0)
		else $error("rtc_write outside clock view");

	// beeping only ever starts in clock view and the menu cannot move while it lasts
	a_buzz_in_clock: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.buzzer |-> rsp_data.view == VIEW_CLOCK)
		else $error("buzzer active outside clock view");

	a_cursor_edit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.cursor != 3'd0 |->
			rsp_data.view == VIEW_EDIT_TIME || rsp_data.view == VIEW_EDIT_ALARM)
		else $error("cursor set outside an edit view");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result changed");

endmodule

bind alarm_clock_setting_controller_top acs_checker u_acs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
